/* hdl/utf8_to_codepage_transcoder_assert.svh */
// Assertion macros for the transcoder port checker
`ifndef UTF8_TO_CODEPAGE_TRANSCODER_ASSERT_SVH
`define UTF8_TO_CODEPAGE_TRANSCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define UTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Next-cycle implication, disabled while reset is low
`define UTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

/* hdl/utp_pkg.sv */
// Shared types, constants and the code point map for the UTF-8 transcoder
package utp_pkg;

  localparam logic [7:0] UNSUP_CHAR = 8'hA8;
  localparam logic [2:0] LEAD2_TAG  = 3'b110;
  localparam logic [3:0] LEAD3_TAG  = 4'b1110;
  localparam logic [4:0] LEAD4_TAG  = 5'b11110;
  localparam logic [1:0] SKIP_LEAD3 = 2'd2;
  localparam logic [1:0] SKIP_OTHER = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [7:0] code;
    logic       bad;
  } utp_res_t;

  function automatic logic [7:0] map_cp(input logic [10:0] cp);
    logic [7:0] ch;
    case (cp)
      11'h0E1: ch = 8'hA0;
      11'h0ED: ch = 8'hA1;
      11'h171: ch = 8'h96;
      11'h151: ch = 8'h93;
      11'h0FC: ch = 8'h81;
      11'h0F6: ch = 8'h94;
      11'h0FA: ch = 8'hA3;
      11'h0F3: ch = 8'hA2;
      11'h0E9: ch = 8'h82;
      11'h0C1: ch = 8'h8E;
      11'h0CD: ch = 8'h8B;
      11'h170: ch = 8'h98;
      11'h150: ch = 8'h97;
      11'h0DC: ch = 8'h9A;
      11'h0D6: ch = 8'h99;
      11'h0DA: ch = 8'h8C;
      11'h0D3: ch = 8'h8D;
      11'h0C9: ch = 8'h90;
      default: ch = UNSUP_CHAR;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/utf8_to_codepage_transcoder.sv */
// Top level: UTF-8 byte stream to modified code page 437 characters
// A byte accepted into the input register reaches out_tvalid through the result register.
// Throughput: one byte per cycle unless a held result stalls on out_tready; skipped and awaiting bytes give no output.
// The sequence decoder state advances once per byte.
// Reset (rst_n low, synchronous) empties both register stages and clears
// the pending skip count and two-byte lead state.
module utf8_to_codepage_transcoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // text_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_code
  output logic       out_tuser   // [0] bad_lead
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_v_r;
  logic [7:0] out_code_r;
  logic       out_bad_r;
  logic       adv;
  utp_pkg::utp_res_t res;

  utp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .data_byte (in_byte_r),
    .text_last (in_last_r),
    .res       (res)
  );

  assign adv       = in_v_r && (!res.vld || !out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && res.vld) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_code_r <= res.code;
      out_bad_r  <= res.bad;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_bad_r;

endmodule

/* hdl/utp_step.sv */
// Per-byte decoder: sequence state and the code point to code page mapping
module utp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                text_last,
  output utp_pkg::utp_res_t   res
);

  logic [1:0] skip_r, skip_nxt;
  logic       await_r, await_nxt;
  logic [4:0] lead_r, lead_nxt;

  always_comb begin
    skip_nxt  = skip_r;
    await_nxt = await_r;
    lead_nxt  = lead_r;
    res.vld   = 1'b0;
    res.code  = utp_pkg::UNSUP_CHAR;
    res.bad   = 1'b0;
    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (await_r) begin
      res.vld   = 1'b1;
      res.code  = utp_pkg::map_cp({lead_r, data_byte[5:0]});
      await_nxt = 1'b0;
    end else if (data_byte inside {[8'h00:8'h7F]}) begin
      res.vld  = 1'b1;
      res.code = data_byte;
    end else if (data_byte[7:5] == utp_pkg::LEAD2_TAG) begin
      lead_nxt = data_byte[4:0];
      if (text_last) begin
        // lead at end of text: zero continuation
        res.vld  = 1'b1;
        res.code = utp_pkg::map_cp({data_byte[4:0], 6'd0});
      end else begin
        await_nxt = 1'b1;
      end
    end else if (data_byte[7:4] == utp_pkg::LEAD3_TAG) begin
      res.vld  = 1'b1;
      skip_nxt = utp_pkg::SKIP_LEAD3;
    end else begin
      res.vld  = 1'b1;
      res.bad  = (data_byte[7:3] != utp_pkg::LEAD4_TAG);
      skip_nxt = utp_pkg::SKIP_OTHER;
    end
    if (text_last) begin
      skip_nxt  = 2'd0;
      await_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= 2'd0;
      await_r <= 1'b0;
      lead_r  <= 5'd0;
    end else if (step_en) begin
      skip_r  <= skip_nxt;
      await_r <= await_nxt;
      lead_r  <= lead_nxt;
    end
  end

endmodule

/* hdl/utp_checker.sv */
// Port-level checker for the transcoder and its bind
`include "utf8_to_codepage_transcoder_assert.svh"

module utp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // stalled result holds
  `UTP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a flagged lead always reports the unsupported character
  `UTP_ASSERT_IMP(a_bad_unsup, clk, rst_n, out_tvalid && out_tuser,
    out_tdata == utp_pkg::UNSUP_CHAR)

  // with the result stage empty the input side never stalls
  `UTP_ASSERT_IMP(a_no_stall, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind utf8_to_codepage_transcoder utp_checker u_utp_checker (.*);

/* test/transcode_checker.sv */
`timescale 1ns / 100ps
// Watches both streams of the UTF-8 transcoder, predicts each character and compares.
module transcode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tuser,
  output int         failures,
  output int         waiting,
  output int         chars_seen,
  output int         flagged_seen
);

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } glyph_t;

  glyph_t     expected_glyphs[$];
  logic [1:0] skip_cnt;
  logic       half_pending;
  logic [4:0] lead_lo;

  initial begin
    failures     = 0;
    chars_seen   = 0;
    flagged_seen = 0;
    skip_cnt     = '0;
    half_pending = 1'b0;
    lead_lo      = '0;
  end

  assign waiting = expected_glyphs.size();

  function automatic logic [7:0] cp437_glyph(input logic [10:0] cp);
    case (cp)
      11'h0E1: return 8'hA0;
      11'h0ED: return 8'hA1;
      11'h171: return 8'h96;
      11'h151: return 8'h93;
      11'h0FC: return 8'h81;
      11'h0F6: return 8'h94;
      11'h0FA: return 8'hA3;
      11'h0F3: return 8'hA2;
      11'h0E9: return 8'h82;
      11'h0C1: return 8'h8E;
      11'h0CD: return 8'h8B;
      11'h170: return 8'h98;
      11'h150: return 8'h97;
      11'h0DC: return 8'h9A;
      11'h0D6: return 8'h99;
      11'h0DA: return 8'h8C;
      11'h0D3: return 8'h8D;
      11'h0C9: return 8'h90;
      default: return utp_pkg::UNSUP_CHAR;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch: %s got %0h expected %0h", $time, what, got, want);
    failures++;
  endtask

  task automatic decode_request(input logic [7:0] b, input logic last);
    glyph_t g;
    logic   emit;
    g    = '0;
    emit = 1'b0;
    if (skip_cnt != 2'd0) begin
      skip_cnt = skip_cnt - 2'd1;
    end else if (half_pending) begin
      g.ch         = cp437_glyph({lead_lo, b[5:0]});
      half_pending = 1'b0;
      emit         = 1'b1;
    end else if (!b[7]) begin
      g.ch = b;
      emit = 1'b1;
    end else if (b[7:5] == utp_pkg::LEAD2_TAG) begin
      lead_lo = b[4:0];
      if (last) begin
        g.ch = cp437_glyph({b[4:0], 6'b0});
        emit = 1'b1;
      end else begin
        half_pending = 1'b1;
      end
    end else if (b[7:4] == utp_pkg::LEAD3_TAG) begin
      g.ch     = utp_pkg::UNSUP_CHAR;
      skip_cnt = utp_pkg::SKIP_LEAD3;
      emit     = 1'b1;
    end else begin
      g.ch     = utp_pkg::UNSUP_CHAR;
      g.bad    = (b[7:3] != utp_pkg::LEAD4_TAG);
      skip_cnt = utp_pkg::SKIP_OTHER;
      emit     = 1'b1;
    end
    if (last) begin
      skip_cnt     = 2'd0;
      half_pending = 1'b0;
    end
    if (emit) expected_glyphs.push_back(g);
  endtask

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_request(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        chars_seen++;
        if (out_tuser) flagged_seen++;
        if (expected_glyphs.size() == 0) begin
          report_mismatch("unexpected character", out_tdata, 0);
        end else begin
          want = expected_glyphs.pop_front();
          if (out_tdata !== want.ch) report_mismatch("char_code", out_tdata, want.ch);
          if (out_tuser !== want.bad) report_mismatch("bad_lead", out_tuser, want.bad);
        end
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the transcoder test: clock, reset, UTF-8 text stimulus, back-pressure and verdict.
module testbench;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_BYTES = 2000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;

  int failures, waiting, chars_seen, flagged_seen;
  int bytes_sent = 0;
  int texts_sent = 0;
  int cycles     = 0;
  bit burst      = 1'b0;

  utf8_to_codepage_transcoder dut (.*);

  transcode_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still due", cycles, waiting);
      $display("utf8_to_codepage_transcoder verification failed");
      $finish;
    end
  end

  // receiver: ready bursts, mostly short stalls, a few long ones
  initial begin
    int pick;
    forever begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else if (pick < 12) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (pick < 19) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(15, 50)) @(posedge clk);
      end
    end
  end

  function automatic logic [10:0] hu_letter(input int idx);
    case (idx)
      0:  return 11'h0E1;
      1:  return 11'h0ED;
      2:  return 11'h171;
      3:  return 11'h151;
      4:  return 11'h0FC;
      5:  return 11'h0F6;
      6:  return 11'h0FA;
      7:  return 11'h0F3;
      8:  return 11'h0E9;
      9:  return 11'h0C1;
      10: return 11'h0CD;
      11: return 11'h170;
      12: return 11'h150;
      13: return 11'h0DC;
      14: return 11'h0D6;
      15: return 11'h0DA;
      16: return 11'h0D3;
      default: return 11'h0C9;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int pick;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (last) texts_sent++;
    gap = 0;
    if (!burst) begin
      pick = $urandom_range(0, 49);
      if (pick >= 49)      gap = $urandom_range(20, 50);
      else if (pick >= 45) gap = $urandom_range(4, 10);
      else if (pick >= 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_text();
    logic [7:0]  text[$];
    logic [10:0] cp;
    int          units;
    int          cut;
    units = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
    repeat (units) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: text.push_back(8'($urandom_range(8'h00, 8'h7F)));
        4, 5, 6: begin
          cp = hu_letter($urandom_range(0, 17));
          text.push_back({3'b110, cp[10:6]});
          text.push_back({2'b10, cp[5:0]});
        end
        7: begin
          text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        8: begin
          text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          repeat (2) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        9: begin
          text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          repeat (3) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        10: text.push_back(8'($urandom_range(0, 255)));
        default: begin
          if ($urandom_range(0, 1)) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
          else                      text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end
      endcase
    end
    // broken text: cut it short at a random byte, which can fall in the middle of a sequence
    if ($urandom_range(0, 5) == 0 && text.size() > 1) begin
      cut = $urandom_range(1, text.size() - 1);
      while (text.size() > cut) void'(text.pop_back());
    end
    burst = ($urandom_range(0, 3) == 0);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);  // a acute
    send_byte(8'hA1, 1'b0);
    send_byte(8'hC5, 1'b0);  // u double acute
    send_byte(8'hB1, 1'b0);
    send_byte(8'hC3, 1'b0);  // continuation taken unchecked
    send_byte(8'h41, 1'b0);
    send_byte(8'hDF, 1'b0);  // unmapped two-byte
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);  // three-byte lead
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);  // four-byte lead
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'hFF, 1'b1);  // bad lead, skip cut by end of text
    send_byte(8'hC3, 1'b1);  // lead as last byte
    send_byte(8'hE1, 1'b1);
    send_byte(8'h41, 1'b1);

    in_tvalid <= 1'b0;
    drain_results();

    while (bytes_sent < TARGET_BYTES) begin
      send_random_text();
      if (!paused && bytes_sent >= TARGET_BYTES / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        drain_results();
        repeat (4) @(posedge clk);
      end
    end

    in_tvalid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("sent %0d bytes in %0d texts (ASCII, accented letters, long and broken sequences)",
             bytes_sent, texts_sent);
    $display("checked %0d characters, %0d with bad lead flagged", chars_seen, flagged_seen);
    if (failures == 0) begin
      $display("utf8_to_codepage_transcoder verification clean");
    end else begin
      $display("%0d mismatches", failures);
      $display("utf8_to_codepage_transcoder verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/utp_pkg.sv
hdl/utp_step.sv
hdl/utf8_to_codepage_transcoder.sv
hdl/utp_checker.sv
test/transcode_checker.sv
test/testbench.sv
